>>> rtl/hbkv_pkg.sv
// Package: widths, sizes and codes for the hashed bucket key/value table.
`timescale 1ns / 1ps
package hbkv_pkg;
  localparam int MaxBuckets  = 64;
  localparam int BucketDepth = 8;
  localparam int MaxKeyBytes = 8;
  localparam int MaxValBytes = 8;
  localparam int Slots       = MaxBuckets * BucketDepth;
  localparam int BktW        = $clog2(MaxBuckets);
  localparam int SlotW       = $clog2(BucketDepth);
  localparam int AddrW       = $clog2(Slots);
  localparam int FillW       = $clog2(BucketDepth + 1);
  localparam int NbW         = 7;

  typedef logic [1:0]  req_t;
  typedef logic [1:0]  status_t;
  typedef logic [63:0] word_t;
  typedef logic [3:0]  len_t;

  localparam req_t ReqInsert = 2'd0;
  localparam req_t ReqFind   = 2'd1;
  localparam req_t ReqSet    = 2'd2;
  localparam req_t ReqDelete = 2'd3;

  localparam status_t StDone     = 2'd0;
  localparam status_t StNotFound = 2'd1;
  localparam status_t StFull     = 2'd2;

  localparam logic [63:0] HashInit = 64'd5381;
  localparam int HashShift = 5;

  // Keep the low len bytes of a word.
  function automatic word_t byte_mask(input len_t len);
    word_t m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (len > len_t'(i)) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction
endpackage

>>> rtl/hashed_bucket_key_value_table_core.sv
// Top level: djb2-hashed bucket key/value table with an iterative sequencer.
`timescale 1ns / 1ps
// A request is taken when start_i is high and busy_o is low; busy_o then stays
// high until the single result is shown on status_o, found_value_o and
// found_value_len_o for one cycle, marked by done_o. The receiver cannot stall
// the result. While busy_o is high a request runs through these steps: the
// hash, one byte per cycle through one shift-add unit; 64 restoring
// compare-subtract steps, one hash bit per cycle, for the remainder by the
// bucket count; the registered read of the bucket fill count; a lookup; then
// a scan of the slots through the registered read port of the entry memory;
// a read and a write to move the last entry on delete; a final state. done_o
// follows in the next cycle with busy_o already low, so the next request can
// be taken in the result cycle. Insert skips the scan. The entry memory is
// never cleared; after reset a pass clears the per-bucket fill counts, with
// busy_o high. num_buckets is written through cfg_valid_i/cfg_ready_o while
// idle; 0 acts as 1 and values above 64 act as 64.
module hashed_bucket_key_value_table_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  hbkv_pkg::req_t       req_type_i,
  input  logic [63:0]          key_bytes_i,
  input  logic [3:0]           key_len_i,
  input  logic [63:0]          value_bytes_i,
  input  logic [3:0]           value_len_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [6:0]           cfg_data_i,
  output logic                 done_o,
  output hbkv_pkg::status_t    status_o,
  output logic [63:0]          found_value_o,
  output logic [3:0]           found_value_len_o
);
  import hbkv_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_MOD, S_FRD, S_LOOK, S_RD, S_CMP, S_LAST, S_MOVE, S_DONE
  } state_e;

  typedef struct packed {
    word_t key;
    len_t  klen;
    word_t val;
    len_t  vlen;
  } entry_t;

  state_e state_q;
  req_t   req_q;
  entry_t cur_q;
  logic [63:0] hash_q;
  logic [3:0]  step_q;
  logic [NbW-1:0] nb_q, nb_eff;
  logic [BktW-1:0] bkt_q;
  logic [FillW-1:0] fill_q;
  logic [SlotW-1:0] slot_q;
  logic [SlotW-1:0] hit_q;
  logic [BktW-1:0] clr_q;

  // Per-bucket fill counts: one write port, one registered read port.
  logic [FillW-1:0] fill_mem [MaxBuckets];
  logic [FillW-1:0] fill_rd_q;
  logic             fill_wr_en;
  logic [BktW-1:0]  fill_wr_addr;
  logic [FillW-1:0] fill_wr_data;

  entry_t mem [Slots];
  entry_t rd_q;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t           wr_data;

  logic [6:0] rem_d;

  len_t klen_sat, vlen_sat;
  assign klen_sat = (key_len_i > len_t'(MaxKeyBytes)) ? len_t'(MaxKeyBytes) : key_len_i;
  assign vlen_sat = (value_len_i > len_t'(MaxValBytes)) ? len_t'(MaxValBytes) : value_len_i;

  always_comb begin
    if (nb_q == '0) nb_eff = NbW'(1);
    else if (nb_q > NbW'(MaxBuckets)) nb_eff = NbW'(MaxBuckets);
    else nb_eff = nb_q;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start_i;

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_wr_en) fill_mem[fill_wr_addr] <= fill_wr_data;
    fill_rd_q <= fill_mem[bkt_q];
  end

  // Clear counts after reset, bump on insert, drop on delete.
  always_comb begin
    fill_wr_en   = 1'b0;
    fill_wr_addr = bkt_q;
    fill_wr_data = fill_rd_q + FillW'(1);
    case (state_q)
      S_CLR: begin
        fill_wr_en   = 1'b1;
        fill_wr_addr = clr_q;
        fill_wr_data = '0;
      end
      S_LOOK: begin
        if (req_q == ReqInsert && fill_rd_q < FillW'(BucketDepth)) fill_wr_en = 1'b1;
      end
      S_MOVE: begin
        fill_wr_en   = 1'b1;
        fill_wr_data = fill_q - FillW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_addr = {bkt_q, slot_q};
    if (state_q == S_LAST) rd_addr = {bkt_q, SlotW'(fill_q - FillW'(1))};
    wr_en   = 1'b0;
    wr_addr = {bkt_q, SlotW'(fill_rd_q)};
    wr_data = cur_q;
    if (state_q == S_LOOK && req_q == ReqInsert && fill_rd_q < FillW'(BucketDepth)) begin
      wr_en = 1'b1;
    end
    if (state_q == S_MOVE) begin
      wr_en   = 1'b1;
      wr_addr = {bkt_q, hit_q};
      wr_data = rd_q;
    end
    if (state_q == S_CMP && req_q == ReqSet &&
        rd_q.klen == cur_q.klen && rd_q.key == cur_q.key) begin
      wr_en   = 1'b1;
      wr_addr = {bkt_q, slot_q};
      wr_data = rd_q;
      wr_data.val  = cur_q.val;
      wr_data.vlen = cur_q.vlen;
    end
  end

  logic match;
  assign match = (rd_q.klen == cur_q.klen) && (rd_q.key == cur_q.key);

  // Restoring remainder: shift in one hash bit per cycle, top bit first.
  logic [6:0] rem_q;
  logic [5:0] bit_q;
  logic [7:0] trial;
  assign trial = {rem_q, hash_q[bit_q]};
  assign rem_d = (trial >= {1'b0, nb_eff}) ? 7'(trial - {1'b0, nb_eff}) : trial[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      nb_q    <= NbW'(MaxBuckets);
      done_o  <= 1'b0;
      clr_q   <= '0;
      step_q  <= '0;
      slot_q  <= '0;
      bit_q   <= '0;
      rem_q   <= '0;
      req_q   <= ReqInsert;
      cur_q   <= '0;
      hash_q  <= '0;
      bkt_q   <= '0;
      fill_q  <= '0;
      hit_q   <= '0;
      status_o <= StDone;
      found_value_o <= '0;
      found_value_len_o <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + BktW'(1);
          if (clr_q == BktW'(MaxBuckets - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid_i && cfg_ready_o) nb_q <= cfg_data_i;
          if (start_i) begin
            req_q     <= req_type_i;
            cur_q.key <= key_bytes_i & byte_mask(klen_sat);
            cur_q.klen <= klen_sat;
            cur_q.val <= value_bytes_i & byte_mask(vlen_sat);
            cur_q.vlen <= vlen_sat;
            hash_q    <= HashInit;
            step_q    <= '0;
            state_q   <= S_HASH;
          end
        end
        S_HASH: begin
          if (step_q < cur_q.klen) begin
            hash_q <= (hash_q << HashShift) + hash_q + 64'(cur_q.key[8*step_q[2:0] +: 8]);
            step_q <= step_q + 4'd1;
          end else begin
            bit_q   <= 6'd63;
            rem_q   <= '0;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          rem_q <= rem_d;
          if (bit_q == '0) begin
            bkt_q   <= BktW'(rem_d);
            state_q <= S_FRD;
          end else begin
            bit_q <= bit_q - 6'd1;
          end
        end
        // Wait for the registered fill count of the bucket.
        S_FRD: state_q <= S_LOOK;
        S_LOOK: begin
          fill_q <= fill_rd_q;
          slot_q <= '0;
          state_q <= S_RD;
          if (req_q == ReqInsert) state_q <= S_DONE;
          if (fill_rd_q == '0) state_q <= S_DONE;
          if (req_q == ReqInsert) begin
            if (fill_rd_q < FillW'(BucketDepth)) begin
              status_o <= StDone;
              found_value_o <= cur_q.val;
              found_value_len_o <= cur_q.vlen;
            end else begin
              status_o <= StFull;
              found_value_o <= '0;
              found_value_len_o <= '0;
            end
          end else begin
            status_o <= StNotFound;
            found_value_o <= '0;
            found_value_len_o <= '0;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (match) begin
            status_o <= StDone;
            hit_q    <= slot_q;
            case (req_q)
              ReqFind: begin
                found_value_o <= rd_q.val;
                found_value_len_o <= rd_q.vlen;
                state_q <= S_DONE;
              end
              ReqSet: begin
                found_value_o <= cur_q.val;
                found_value_len_o <= cur_q.vlen;
                state_q <= S_DONE;
              end
              default: state_q <= S_LAST;
            endcase
          end else if (FillW'(slot_q) + FillW'(1) >= fill_q) begin
            state_q <= S_DONE;
          end else begin
            slot_q  <= slot_q + SlotW'(1);
            state_q <= S_RD;
          end
        end
        S_LAST: state_q <= S_MOVE;
        S_MOVE: state_q <= S_DONE;
        S_DONE: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy after done");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |-> fill_rd_q <= FillW'(BucketDepth))
    else $error("fill overflow");
endmodule

>>> tb/tb_hashed_bucket_key_value_table_core.sv
// Testbench for the hashed bucket key/value table: predicts each result and checks it.
`timescale 1ns / 1ps
module tb_hashed_bucket_key_value_table_core;
  import hbkv_pkg::*;

  typedef struct {
    req_t  op;
    word_t key;
    len_t  klen;
    word_t val;
    len_t  vlen;
  } table_req_t;

  typedef struct {
    status_t st;
    word_t   val;
    len_t    vlen;
  } table_rsp_t;

  localparam int WatchLimit = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  req_t       req_type_i = ReqInsert;
  logic [63:0] key_bytes_i = '0;
  logic [3:0] key_len_i = '0;
  logic [63:0] value_bytes_i = '0;
  logic [3:0] value_len_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic [6:0] cfg_data_i = '0;
  logic       busy_o, cfg_ready_o, done_o;
  status_t    status_o;
  logic [63:0] found_value_o;
  logic [3:0] found_value_len_o;

  hashed_bucket_key_value_table_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table.
  word_t   shadow_key  [Slots];
  len_t    shadow_klen [Slots];
  word_t   shadow_val  [Slots];
  len_t    shadow_vlen [Slots];
  int      shadow_fill [MaxBuckets];
  int      shadow_nb;

  table_req_t pending_reqs[$];
  table_rsp_t expected_rsps[$];
  int         mismatches;
  int         idle_cycles;
  logic       cfg_pending;
  logic [6:0] cfg_word;

  function automatic word_t keep_bytes(input int n);
    word_t m;
    m = '0;
    for (int i = 0; i < n; i++) m[8*i +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic int pick_bucket(input word_t key, input int klen);
    logic [63:0] h;
    int nb;
    h = 64'd5381;
    for (int i = 0; i < klen; i++) h = (h << 5) + h + 64'(key[8*i +: 8]);
    nb = shadow_nb == 0 ? 1 : (shadow_nb > MaxBuckets ? MaxBuckets : shadow_nb);
    return int'(h % 64'(nb));
  endfunction

  // Apply one request to the shadow table and queue the expected response.
  task automatic predict_table(input table_req_t r);
    int klen, vlen, b, base, fill, pos, last;
    word_t key, val;
    table_rsp_t e;
    klen = r.klen > MaxKeyBytes ? MaxKeyBytes : int'(r.klen);
    vlen = r.vlen > MaxValBytes ? MaxValBytes : int'(r.vlen);
    key = r.key & keep_bytes(klen);
    val = r.val & keep_bytes(vlen);
    b = pick_bucket(key, klen);
    base = b * BucketDepth;
    fill = shadow_fill[b];
    pos = -1;
    e.st = StNotFound;
    e.val = '0;
    e.vlen = '0;
    if (r.op == ReqInsert) begin
      if (fill >= BucketDepth) begin
        e.st = StFull;
      end else begin
        shadow_key[base+fill] = key;
        shadow_klen[base+fill] = len_t'(klen);
        shadow_val[base+fill] = val;
        shadow_vlen[base+fill] = len_t'(vlen);
        shadow_fill[b] = fill + 1;
        e.st = StDone;
        e.val = val;
        e.vlen = len_t'(vlen);
      end
    end else begin
      for (int s = 0; s < fill; s++) begin
        if (pos < 0 && shadow_klen[base+s] == len_t'(klen) && shadow_key[base+s] == key)
          pos = base + s;
      end
      if (pos >= 0) begin
        e.st = StDone;
        case (r.op)
          ReqFind: begin
            e.val = shadow_val[pos];
            e.vlen = shadow_vlen[pos];
          end
          ReqSet: begin
            shadow_val[pos] = val;
            shadow_vlen[pos] = len_t'(vlen);
            e.val = val;
            e.vlen = len_t'(vlen);
          end
          default: begin
            last = base + fill - 1;
            shadow_key[pos] = shadow_key[last];
            shadow_klen[pos] = shadow_klen[last];
            shadow_val[pos] = shadow_val[last];
            shadow_vlen[pos] = shadow_vlen[last];
            shadow_fill[b] = fill - 1;
          end
        endcase
      end
    end
    expected_rsps.push_back(e);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: hold each request after a random gap until it is accepted.
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_table(pending_reqs.pop_front());
        gap_left <= $urandom_range(0, 13);
        start_i <= 1'b0;
      end else if (!start_i && pending_reqs.size() > 0 && !cfg_pending) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          start_i <= 1'b1;
          req_type_i <= pending_reqs[0].op;
          key_bytes_i <= pending_reqs[0].key;
          key_len_i <= pending_reqs[0].klen;
          value_bytes_i <= pending_reqs[0].val;
          value_len_i <= pending_reqs[0].vlen;
        end
      end
      // Register write channel.
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_nb = int'(cfg_word);
        cfg_valid_i <= 1'b0;
        cfg_pending <= 1'b0;
      end else if (cfg_pending && !cfg_valid_i) begin
        cfg_valid_i <= 1'b1;
        cfg_data_i <= cfg_word;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    table_rsp_t e;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", 64'(status_o), 64'd0);
        end else begin
          e = expected_rsps.pop_front();
          if (status_o !== e.st) report_mismatch("status", 64'(status_o), 64'(e.st));
          if (found_value_o !== e.val) report_mismatch("found_value", found_value_o, e.val);
          if (found_value_len_o !== e.vlen)
            report_mismatch("found_value_len", 64'(found_value_len_o), 64'(e.vlen));
        end
      end
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Keys drawn from a small pool so finds, sets and deletes hit often.
  word_t key_pool[16];
  len_t  klen_pool[16];

  function automatic table_req_t random_req();
    table_req_t r;
    int k;
    k = $urandom_range(0, 15);
    r.op = req_t'($urandom_range(0, 3));
    r.val = {$urandom, $urandom};
    r.vlen = len_t'($urandom_range(0, 10) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 8));
    if ($urandom_range(0, 9) == 0) begin
      r.key = {$urandom, $urandom};
      r.klen = len_t'($urandom_range(0, 15));
    end else begin
      // same key with random junk above its length
      r.key = key_pool[k] | ({$urandom, $urandom} & ~keep_bytes(int'(klen_pool[k])));
      r.klen = klen_pool[k];
    end
    return r;
  endfunction

  task automatic push_req(input req_t op, input word_t key, input len_t klen,
                          input word_t val, input len_t vlen);
    table_req_t r;
    r.op = op; r.key = key; r.klen = klen; r.val = val; r.vlen = vlen;
    pending_reqs.push_back(r);
  endtask

  // Wait for every request to finish, then write the register.
  task automatic write_buckets(input logic [6:0] nb);
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !start_i);
    repeat (40) @(posedge clk_i);
    cfg_word = nb;
    cfg_pending = 1'b1;
    wait (!cfg_pending);
    @(posedge clk_i);
  endtask

  initial begin
    int n;
    mismatches = 0;
    idle_cycles = 0;
    cfg_pending = 1'b0;
    cfg_word = '0;
    shadow_nb = 64;
    for (int i = 0; i < MaxBuckets; i++) shadow_fill[i] = 0;
    for (int i = 0; i < 16; i++) begin
      klen_pool[i] = len_t'($urandom_range(0, 8));
      key_pool[i] = {$urandom, $urandom} & keep_bytes(int'(klen_pool[i]));
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every operation, over-long lengths, full bucket, misses.
    push_req(ReqFind, 64'h1, 4'd1, '0, '0);
    push_req(ReqInsert, '1, 4'd8, '1, 4'd8);
    push_req(ReqInsert, '0, 4'd0, 64'h55, 4'd0);
    push_req(ReqFind, '1, 4'd15, '0, '0);
    push_req(ReqFind, 64'hFFFF, 4'd0, '0, '0);
    push_req(ReqSet, '1, 4'd8, 64'hA5A5_A5A5_A5A5_A5A5, 4'd15);
    push_req(ReqFind, '1, 4'd8, '0, '0);
    push_req(ReqSet, 64'h77, 4'd1, '1, 4'd3);
    push_req(ReqDelete, 64'h77, 4'd1, '0, '0);
    push_req(ReqDelete, '1, 4'd8, '0, '0);
    push_req(ReqFind, '1, 4'd8, '0, '0);
    wait (pending_reqs.size() == 0);
    write_buckets(7'd1);
    // One bucket: fill it, overflow, delete the middle, find the moved one.
    for (int i = 0; i < 9; i++) push_req(ReqInsert, 64'(i + 1), 4'd1, 64'(i * 3), 4'd2);
    push_req(ReqDelete, 64'd3, 4'd1, '0, '0);
    push_req(ReqFind, 64'd8, 4'd1, '0, '0);
    push_req(ReqInsert, 64'd3, 4'd1, '1, 4'd8);
    push_req(ReqFind, 64'd3, 4'd1, '0, '0);

    // Random phases over several bucket counts, extremes included.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_buckets(7'd0);
        1: write_buckets(7'd64);
        2: write_buckets(7'd127);
        3: write_buckets(7'd2);
        default: write_buckets(7'($urandom_range(1, 127)));
      endcase
      n = 100;
      for (int i = 0; i < n; i++) pending_reqs.push_back(random_req());
    end
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog on cycles without any handshake.
  initial begin
    wait (idle_cycles >= WatchLimit);
    $display("Verification failed");
    $finish;
  end
endmodule
